// File: hdl/itpc_pkg.sv
`default_nettype none

package itpc_pkg;

    // Default sizes
    localparam int STACK_DEPTH_DEF     = 32;
    localparam int SURFACE_ID_BITS_DEF = 16;
    localparam int SID_W               = 16;
    localparam int KIND_W              = 3;
    localparam int STATUS_W            = 3;

    // Infix token kinds
    localparam logic [KIND_W-1:0] TK_SURFACE = 3'd0;
    localparam logic [KIND_W-1:0] TK_TRUE    = 3'd1;
    localparam logic [KIND_W-1:0] TK_OPEN    = 3'd2;
    localparam logic [KIND_W-1:0] TK_CLOSE   = 3'd3;
    localparam logic [KIND_W-1:0] TK_OR      = 3'd4;
    localparam logic [KIND_W-1:0] TK_AND     = 3'd5;
    localparam logic [KIND_W-1:0] TK_NOT     = 3'd6;

    // Postfix kind of a surface operand result; also carried by an error result
    localparam logic [KIND_W-1:0] OUT_SURFACE = 3'd0;

    // Stack entry codes; an operator's postfix kind is its code plus one
    localparam logic [1:0] SC_OPEN = 2'd0;
    localparam logic [1:0] SC_OR   = 2'd1;
    localparam logic [1:0] SC_AND  = 2'd2;
    localparam logic [1:0] SC_NOT  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_OK              = 3'd0;
    localparam logic [STATUS_W-1:0] STS_BAD_OPERAND     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_BAD_OPERATOR    = 3'd2;
    localparam logic [STATUS_W-1:0] STS_UNMATCHED_CLOSE = 3'd3;
    localparam logic [STATUS_W-1:0] STS_UNMATCHED_OPEN  = 3'd4;
    localparam logic [STATUS_W-1:0] STS_END_OPERAND     = 3'd5;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW        = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_POP,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PM_CLOSE,
        PM_OP,
        PM_FLUSH
    } pop_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [SID_W-1:0]  surface_id;
        logic              last_token;
    } tok_t;

    typedef struct packed {
        logic [KIND_W-1:0]   out_kind;
        logic [SID_W-1:0]    out_surface_id;
        logic [STATUS_W-1:0] status;
        logic                run_last;
        logic                expression_done;
    } post_t;

endpackage

`default_nettype wire

// File: hdl/infix_to_postfix_logic_converter.sv
`default_nettype none

// Channel   Dir  Handshake              Payload
// tok       in   tok_valid / tok_stall  itpc_pkg::tok_t  (one infix token)
// post      out  post_valid/ post_stall itpc_pkg::post_t (one postfix token or error)
//
// A token is accepted in S_IDLE, then evaluated in S_EVAL against the stack top,
// which is read ahead into a register; an open or a not is pushed in S_EVAL. A close,
// an and, an or or a flushing last token then pops its operators one at a time in
// S_POP and ends the pop loop there, and any token with a result or a pop loop
// ends in S_FINISH, which hands over its final result.
// A stall on post holds pops and hand-over; reset leaves the stack memory as is.

module infix_to_postfix_logic_converter #(
    parameter int STACK_DEPTH     = itpc_pkg::STACK_DEPTH_DEF,
    parameter int SURFACE_ID_BITS = itpc_pkg::SURFACE_ID_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            tok_valid,
    output logic                 tok_stall,
    input  wire itpc_pkg::tok_t  tok,
    output logic                 post_valid,
    input  wire logic            post_stall,
    output itpc_pkg::post_t      post
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Stack memory and its read register
    logic [1:0]    stack_mem [STACK_DEPTH];
    logic [1:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [1:0]    mem_wdata;

    itpc_pkg::state_t    state_reg, state_next;
    itpc_pkg::pop_mode_t mode_reg, mode_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       open_cnt_reg, open_cnt_next;
    logic                want_reg, want_next;
    logic                drop_reg, drop_next;
    logic                fin_done_reg, fin_done_next;
    itpc_pkg::tok_t      tok_reg, tok_next;
    logic                pend_valid_reg, pend_valid_next;
    itpc_pkg::post_t     pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    itpc_pkg::post_t     out_reg;
    logic                out_load;
    itpc_pkg::post_t     out_data;

    logic [itpc_pkg::SID_W-1:0]    sid_mask;
    logic [1:0]                    top;
    logic [1:0]                    prec;
    logic                          has_top;
    logic                          full;
    logic                          poppable;
    logic                          last;
    logic                          out_free;
    logic                          can_emit;
    logic                          do_pop;
    logic [itpc_pkg::STATUS_W-1:0] err;

    // Keep only the configured number of surface index bits
    always_comb
    begin
        for (int i = 0; i < itpc_pkg::SID_W; i++)
        begin
            sid_mask[i] = (i < SURFACE_ID_BITS);
        end
    end

    assign top      = rd_data_reg;
    assign has_top  = (cnt_reg != '0);
    assign full     = (cnt_reg == CW'(STACK_DEPTH));
    assign prec     = (tok_reg.token_kind == itpc_pkg::TK_AND) ? itpc_pkg::SC_AND
                                                                : itpc_pkg::SC_OR;
    assign poppable = has_top && (top != itpc_pkg::SC_OPEN) && (top >= prec);
    assign last     = tok_reg.last_token;
    assign out_free = !out_valid_reg || !post_stall;
    assign can_emit = !pend_valid_reg || out_free;

    // Classify the token against the state before any result is released
    always_comb
    begin
        err = itpc_pkg::STS_OK;
        case (tok_reg.token_kind)
            itpc_pkg::TK_SURFACE, itpc_pkg::TK_TRUE:
            begin
                if (!want_reg)
                    err = itpc_pkg::STS_BAD_OPERAND;
                else if (last && open_cnt_reg != '0)
                    err = itpc_pkg::STS_UNMATCHED_OPEN;
            end
            itpc_pkg::TK_OPEN, itpc_pkg::TK_NOT:
            begin
                if (!want_reg)
                    err = itpc_pkg::STS_BAD_OPERAND;
                else if (full)
                    err = itpc_pkg::STS_OVERFLOW;
                else if (last)
                    err = itpc_pkg::STS_END_OPERAND;
            end
            itpc_pkg::TK_CLOSE:
            begin
                if (want_reg)
                    err = itpc_pkg::STS_BAD_OPERATOR;
                else if (open_cnt_reg == '0)
                    err = itpc_pkg::STS_UNMATCHED_CLOSE;
                else if (last && open_cnt_reg != CW'(1))
                    err = itpc_pkg::STS_UNMATCHED_OPEN;
            end
            itpc_pkg::TK_OR, itpc_pkg::TK_AND:
            begin
                if (want_reg)
                    err = itpc_pkg::STS_BAD_OPERATOR;
                else if (full && !poppable)
                    err = itpc_pkg::STS_OVERFLOW;
                else if (last)
                    err = itpc_pkg::STS_END_OPERAND;
            end
            default:
            begin
                if (last && want_reg)
                    err = itpc_pkg::STS_END_OPERAND;
                else if (last && open_cnt_reg != '0)
                    err = itpc_pkg::STS_UNMATCHED_OPEN;
            end
        endcase
    end

    // Sequencer: next state, stack updates and result hand-over
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cnt_next        = cnt_reg;
        open_cnt_next   = open_cnt_reg;
        want_next       = want_reg;
        drop_next       = drop_reg;
        fin_done_next   = fin_done_reg;
        tok_next        = tok_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_load        = 1'b0;
        out_data        = pend_reg;
        mem_we          = 1'b0;
        mem_wdata       = itpc_pkg::SC_OPEN;
        do_pop          = 1'b0;
        tok_stall       = (state_reg != itpc_pkg::S_IDLE);

        case (state_reg)
            itpc_pkg::S_IDLE:
            begin
                if (tok_valid)
                begin
                    tok_next   = tok;
                    state_next = itpc_pkg::S_EVAL;
                end
            end

            itpc_pkg::S_EVAL:
            begin
                state_next = itpc_pkg::S_IDLE;
                if (drop_reg)
                begin
                    // Drop tokens until the expression ends
                    if (last)
                    begin
                        cnt_next      = '0;
                        open_cnt_next = '0;
                        want_next     = 1'b1;
                        drop_next     = 1'b0;
                    end
                end
                else if (err != itpc_pkg::STS_OK)
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = '{itpc_pkg::OUT_SURFACE, '0, err, 1'b0, 1'b0};
                    fin_done_next   = 1'b1;
                    state_next      = itpc_pkg::S_FINISH;
                    if (last)
                    begin
                        cnt_next      = '0;
                        open_cnt_next = '0;
                        want_next     = 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                else
                begin
                    fin_done_next = last;
                    mode_next     = itpc_pkg::PM_FLUSH;
                    case (tok_reg.token_kind)
                        itpc_pkg::TK_SURFACE, itpc_pkg::TK_TRUE:
                        begin
                            pend_valid_next          = 1'b1;
                            pend_next                = '0;
                            pend_next.out_kind       = tok_reg.token_kind;
                            pend_next.out_surface_id =
                                (tok_reg.token_kind == itpc_pkg::TK_SURFACE)
                                ? (tok_reg.surface_id & sid_mask) : '0;
                            want_next  = 1'b0;
                            state_next = last ? itpc_pkg::S_POP : itpc_pkg::S_FINISH;
                        end
                        itpc_pkg::TK_OPEN:
                        begin
                            mem_we        = 1'b1;
                            mem_wdata     = itpc_pkg::SC_OPEN;
                            cnt_next      = cnt_reg + 1'b1;
                            open_cnt_next = open_cnt_reg + 1'b1;
                        end
                        itpc_pkg::TK_NOT:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = itpc_pkg::SC_NOT;
                            cnt_next  = cnt_reg + 1'b1;
                            want_next = 1'b1;
                        end
                        itpc_pkg::TK_CLOSE:
                        begin
                            mode_next  = itpc_pkg::PM_CLOSE;
                            state_next = itpc_pkg::S_POP;
                        end
                        itpc_pkg::TK_OR, itpc_pkg::TK_AND:
                        begin
                            mode_next  = itpc_pkg::PM_OP;
                            want_next  = 1'b1;
                            state_next = itpc_pkg::S_POP;
                        end
                        default:
                        begin
                            if (last)
                                state_next = itpc_pkg::S_POP;
                        end
                    endcase
                end
            end

            itpc_pkg::S_POP:
            begin
                case (mode_reg)
                    itpc_pkg::PM_CLOSE:
                    begin
                        if (top != itpc_pkg::SC_OPEN)
                        begin
                            do_pop = 1'b1;
                        end
                        else
                        begin
                            // Discard the matching open
                            cnt_next      = cnt_reg - 1'b1;
                            open_cnt_next = open_cnt_reg - 1'b1;
                            if (last)
                                mode_next = itpc_pkg::PM_FLUSH;
                            else
                                state_next = itpc_pkg::S_FINISH;
                        end
                    end
                    itpc_pkg::PM_OP:
                    begin
                        if (poppable)
                        begin
                            do_pop = 1'b1;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_wdata  = prec;
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = itpc_pkg::S_FINISH;
                        end
                    end
                    default:
                    begin
                        if (has_top)
                        begin
                            do_pop = 1'b1;
                        end
                        else
                        begin
                            want_next  = 1'b1;
                            drop_next  = 1'b0;
                            state_next = itpc_pkg::S_FINISH;
                        end
                    end
                endcase

                // Release the top operator once the pending slot can move on
                if (do_pop && can_emit)
                begin
                    out_load           = pend_valid_reg;
                    pend_valid_next    = 1'b1;
                    pend_next          = '0;
                    pend_next.out_kind = {1'b0, top} + 3'd1;
                    cnt_next           = cnt_reg - 1'b1;
                end
            end

            itpc_pkg::S_FINISH:
            begin
                // Mark the final result of this request
                out_data.run_last        = 1'b1;
                out_data.expression_done = fin_done_reg;
                if (!pend_valid_reg)
                begin
                    state_next = itpc_pkg::S_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = itpc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = itpc_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && post_stall);
    assign mem_waddr      = cnt_reg[AW-1:0];
    assign mem_raddr      = (cnt_next == '0) ? '0 : AW'(cnt_next - 1'b1);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= itpc_pkg::S_IDLE;
            mode_reg       <= itpc_pkg::PM_FLUSH;
            cnt_reg        <= '0;
            open_cnt_reg   <= '0;
            want_reg       <= 1'b1;
            drop_reg       <= 1'b0;
            fin_done_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            cnt_reg        <= cnt_next;
            open_cnt_reg   <= open_cnt_next;
            want_reg       <= want_next;
            drop_reg       <= drop_next;
            fin_done_reg   <= fin_done_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        pend_reg <= pend_next;
        if (out_load)
            out_reg <= out_data;
    end

    // Write the stack and read the next top ahead into a register
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= stack_mem[mem_raddr];
    end

    assign post_valid = out_valid_reg;
    assign post       = out_reg;

    // The top used by the pop loop must not come from a read that raced a push
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itpc_pkg::S_POP) |-> !$past(mem_we))
        else $error("pop loop reads a stale stack top");

    assert property (@(posedge clk) disable iff (!rst_n)
        (open_cnt_reg <= cnt_reg) && (cnt_reg <= CW'(STACK_DEPTH)))
        else $error("stack counters out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itpc_pkg::S_IDLE) |-> !pend_valid_reg)
        else $error("result left pending between requests");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !post_stall))
        else $error("output register overwritten while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itpc_pkg::S_EVAL)
        |=> ({1'b0, cnt_reg} <= ({1'b0, $past(cnt_reg)} + 1'b1)))
        else $error("stack grew by more than one entry");

endmodule

`default_nettype wire

// File: tb/postfix_checker.sv
`timescale 1ns / 1ps

module postfix_checker #(
    parameter int STACK_DEPTH     = itpc_pkg::STACK_DEPTH_DEF,
    parameter int SURFACE_ID_BITS = itpc_pkg::SURFACE_ID_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            tok_valid,
    input  wire logic            tok_stall,
    input  wire itpc_pkg::tok_t  tok,
    input  wire logic            post_valid,
    input  wire logic            post_stall,
    input  wire itpc_pkg::post_t post,
    output int                   mismatches,
    output int                   due_count
);

    localparam int KIND_W   = itpc_pkg::KIND_W;
    localparam int SID_W    = itpc_pkg::SID_W;
    localparam int STATUS_W = itpc_pkg::STATUS_W;
    localparam logic [SID_W-1:0] SID_MASK = SID_W'((64'd1 << SURFACE_ID_BITS) - 64'd1);

    logic [1:0]      op_stack [STACK_DEPTH];
    int              op_depth;
    bit              want_operand;
    bit              dropping;
    itpc_pkg::post_t released [$];
    itpc_pkg::post_t postfix_due [$];
    itpc_pkg::post_t oldest;
    int              mismatch_tally;

    function automatic bit open_pending();
        for (int i = 0; i < op_depth; i++)
        begin
            if (op_stack[i] == itpc_pkg::SC_OPEN)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void restart_expression();
        op_depth     = 0;
        want_operand = 1'b1;
        dropping     = 1'b0;
    endfunction

    // Pop the top operator into this request's postfix tokens
    task automatic release_top();
        itpc_pkg::post_t r;
        r = '0;
        op_depth--;
        r.out_kind = KIND_W'(op_stack[op_depth]) + KIND_W'(1);
        released.insert(released.size(), r);
    endtask

    task automatic push_op(input logic [1:0] code, inout logic [STATUS_W-1:0] fault);
        if (op_depth >= STACK_DEPTH)
            fault = itpc_pkg::STS_OVERFLOW;
        else
        begin
            op_stack[op_depth] = code;
            op_depth++;
        end
    endtask

    // Work out the postfix tokens one infix request releases
    task automatic convert_token(input itpc_pkg::tok_t t);
        logic [STATUS_W-1:0] fault;
        logic [1:0]          prec;
        itpc_pkg::post_t     r;
        fault = itpc_pkg::STS_OK;
        released.delete();

        // swallow everything up to the end of a faulty expression
        if (dropping)
        begin
            if (t.last_token)
                restart_expression();
            return;
        end

        case (t.token_kind)
            itpc_pkg::TK_SURFACE, itpc_pkg::TK_TRUE:
            begin
                if (!want_operand)
                    fault = itpc_pkg::STS_BAD_OPERAND;
                else
                begin
                    r = '0;
                    r.out_kind = t.token_kind;
                    if (t.token_kind == itpc_pkg::TK_SURFACE)
                        r.out_surface_id = t.surface_id & SID_MASK;
                    released.insert(released.size(), r);
                    want_operand = 1'b0;
                end
            end
            itpc_pkg::TK_OPEN:
            begin
                if (!want_operand)
                    fault = itpc_pkg::STS_BAD_OPERAND;
                else
                    push_op(itpc_pkg::SC_OPEN, fault);
            end
            itpc_pkg::TK_CLOSE:
            begin
                if (want_operand)
                    fault = itpc_pkg::STS_BAD_OPERATOR;
                else if (!open_pending())
                    fault = itpc_pkg::STS_UNMATCHED_CLOSE;
                else
                begin
                    while (op_depth > 0 && op_stack[op_depth-1] != itpc_pkg::SC_OPEN)
                        release_top();
                    if (op_depth > 0)
                        op_depth--;
                end
            end
            itpc_pkg::TK_OR, itpc_pkg::TK_AND:
            begin
                prec = (t.token_kind == itpc_pkg::TK_OR) ? itpc_pkg::SC_OR
                                                         : itpc_pkg::SC_AND;
                if (want_operand)
                    fault = itpc_pkg::STS_BAD_OPERATOR;
                else
                begin
                    while (op_depth > 0 && op_stack[op_depth-1] != itpc_pkg::SC_OPEN
                           && op_stack[op_depth-1] >= prec)
                        release_top();
                    push_op(prec, fault);
                    want_operand = 1'b1;
                end
            end
            itpc_pkg::TK_NOT:
            begin
                // right-associative: never pops
                if (!want_operand)
                    fault = itpc_pkg::STS_BAD_OPERAND;
                else
                begin
                    push_op(itpc_pkg::SC_NOT, fault);
                    want_operand = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // end-of-expression checks, then flush the stack
        if (fault == itpc_pkg::STS_OK && t.last_token)
        begin
            if (want_operand)
                fault = itpc_pkg::STS_END_OPERAND;
            else if (open_pending())
                fault = itpc_pkg::STS_UNMATCHED_OPEN;
            else
                while (op_depth > 0)
                    release_top();
        end

        // a fault replaces everything released with one error result
        if (fault != itpc_pkg::STS_OK)
        begin
            r = '0;
            r.out_kind        = itpc_pkg::OUT_SURFACE;
            r.status          = fault;
            r.run_last        = 1'b1;
            r.expression_done = 1'b1;
            postfix_due.insert(postfix_due.size(), r);
            if (t.last_token)
                restart_expression();
            else
                dropping = 1'b1;
            return;
        end

        if (released.size() > 0)
        begin
            released[$].run_last        = 1'b1;
            released[$].expression_done = t.last_token;
        end
        foreach (released[i])
            postfix_due.insert(postfix_due.size(), released[i]);
        if (t.last_token)
            restart_expression();
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_tally++;
        end
    endtask

    // Predict on each accepted request, compare each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_expression();
            postfix_due.delete();
            mismatch_tally = 0;
            mismatches     <= 0;
            due_count      <= 0;
        end
        else
        begin
            if (tok_valid && !tok_stall)
                convert_token(tok);

            if (post_valid && !post_stall)
            begin
                if (postfix_due.size() == 0)
                begin
                    $error("postfix result with none expected: out_kind %0d status %0d",
                           post.out_kind, post.status);
                    mismatch_tally++;
                end
                else
                begin
                    oldest = postfix_due.pop_front();
                    check_field("out_kind", oldest.out_kind, post.out_kind);
                    check_field("out_surface_id", oldest.out_surface_id,
                                post.out_surface_id);
                    check_field("status", oldest.status, post.status);
                    check_field("run_last", oldest.run_last, post.run_last);
                    check_field("expression_done", oldest.expression_done,
                                post.expression_done);
                end
            end

            mismatches <= mismatch_tally;
            due_count  <= postfix_due.size();
        end
    end

endmodule

// File: tb/tb_infix_to_postfix_logic_converter.sv
`timescale 1ns / 1ps

module tb_infix_to_postfix_logic_converter;

    localparam int DEPTH        = itpc_pkg::STACK_DEPTH_DEF;
    localparam int ID_BITS      = itpc_pkg::SURFACE_ID_BITS_DEF;
    localparam int KIND_W       = itpc_pkg::KIND_W;
    localparam int SID_W        = itpc_pkg::SID_W;
    localparam int ITEM_GOAL    = 410;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;

    // token kind the block does not define
    localparam logic [KIND_W-1:0] TK_UNUSED = 3'd7;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            tok_valid  = 1'b0;
    logic            tok_stall;
    itpc_pkg::tok_t  tok        = '0;
    logic            post_valid;
    logic            post_stall = 1'b0;
    itpc_pkg::post_t post;
    int              mismatches;
    int              due_count;

    itpc_pkg::tok_t  infix_q [$];
    bit              gappy;
    int              burst_left;
    int              sent_total = 0;
    stall_mode_t     stall_mode = STALL_NONE;
    int              stall_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    infix_to_postfix_logic_converter #(
        .STACK_DEPTH     (DEPTH),
        .SURFACE_ID_BITS (ID_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok        (tok),
        .post_valid (post_valid),
        .post_stall (post_stall),
        .post       (post)
    );

    postfix_checker #(
        .STACK_DEPTH     (DEPTH),
        .SURFACE_ID_BITS (ID_BITS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_valid   (tok_valid),
        .tok_stall   (tok_stall),
        .tok         (tok),
        .post_valid  (post_valid),
        .post_stall  (post_stall),
        .post        (post),
        .mismatches  (mismatches),
        .due_count   (due_count)
    );

    // Vary back-pressure on results: free flow, light, heavy or periodic
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end
        else
            stall_left--;
        case (stall_mode)
            STALL_NONE:  post_stall <= 1'b0;
            STALL_LIGHT: post_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY: post_stall <= ($urandom_range(0, 99) < 70);
            default:     post_stall <= (stall_left % 3 == 0);
        endcase
    end

    function automatic logic [SID_W-1:0] pick_id();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return SID_W'($urandom);
        endcase
    endfunction

    function automatic void push_token(logic [KIND_W-1:0] kind, logic [SID_W-1:0] id,
                                       bit last);
        itpc_pkg::tok_t t;
        t.token_kind = kind;
        t.surface_id = id;
        t.last_token = last;
        infix_q.insert(infix_q.size(), t);
    endfunction

    // Present queued requests, with bursts and gaps when gappy
    task automatic send_tokens();
        int gap;
        while (infix_q.size() > 0)
        begin
            if (gappy && burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(0, 6);
                if (gap > 0)
                begin
                    @(negedge clk);
                    tok_valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            if (burst_left > 0)
                burst_left--;
            @(negedge clk);
            tok       <= infix_q.pop_front();
            tok_valid <= 1'b1;
            do @(posedge clk); while (tok_stall);
            sent_total++;
        end
    endtask

    // Hold the sender off until every expected result has come
    task automatic hold_until_drained(int settle);
        @(negedge clk);
        tok_valid <= 1'b0;
        wait (due_count == 0);
        repeat (settle) @(posedge clk);
    endtask

    // Build a well-formed operand expression of bounded nesting
    task automatic grow_expr(int lvl);
        int pick;
        pick = (lvl >= 3) ? 0 : $urandom_range(0, 9);
        if (pick <= 3)
        begin
            if ($urandom_range(0, 3) == 0)
                push_token(itpc_pkg::TK_TRUE, pick_id(), 1'b0);
            else
                push_token(itpc_pkg::TK_SURFACE, pick_id(), 1'b0);
        end
        else if (pick <= 5)
        begin
            push_token(itpc_pkg::TK_NOT, pick_id(), 1'b0);
            grow_expr(lvl + 1);
        end
        else if (pick <= 7)
        begin
            push_token(itpc_pkg::TK_OPEN, pick_id(), 1'b0);
            grow_expr(lvl + 1);
            push_token(itpc_pkg::TK_CLOSE, pick_id(), 1'b0);
        end
        else
        begin
            grow_expr(lvl + 1);
            push_token($urandom_range(0, 1) ? itpc_pkg::TK_AND : itpc_pkg::TK_OR,
                       pick_id(), 1'b0);
            grow_expr(lvl + 1);
        end
    endtask

    // Break one token of a well-formed expression: retype, drop or insert
    task automatic scramble_tokens();
        int             idx;
        itpc_pkg::tok_t t;
        idx          = $urandom_range(0, infix_q.size() - 1);
        t.token_kind = KIND_W'($urandom_range(0, 7));
        t.surface_id = pick_id();
        t.last_token = 1'b0;
        case ($urandom_range(0, 2))
            0:       infix_q[idx].token_kind = t.token_kind;
            1:       if (infix_q.size() > 1) infix_q.delete(idx);
            default: infix_q.insert(idx, t);
        endcase
        foreach (infix_q[i])
            infix_q[i].last_token = 1'b0;
        infix_q[$].last_token = 1'b1;
    endtask

    // Any kinds at all, with stray end marks
    task automatic make_noise();
        repeat ($urandom_range(1, 10))
            push_token(KIND_W'($urandom_range(0, 7)), pick_id(),
                       $urandom_range(0, 99) < 15);
        infix_q[$].last_token = 1'b1;
    endtask

    // Nest nots or opens around one operand, near the stack limit
    task automatic build_deep(logic [KIND_W-1:0] kind, int levels);
        repeat (levels)
            push_token(kind, pick_id(), 1'b0);
        push_token(itpc_pkg::TK_SURFACE, pick_id(), 1'b0);
        if (kind == itpc_pkg::TK_OPEN && levels <= DEPTH)
            repeat (levels)
                push_token(itpc_pkg::TK_CLOSE, pick_id(), 1'b0);
        infix_q[$].last_token = 1'b1;
    endtask

    initial
    begin : stimulus
        int round;
        int pick;
        gappy      = 1'b1;
        burst_left = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // unused kind after an operand: nothing left to release, silent end
        push_token(itpc_pkg::TK_SURFACE, 16'h0000, 1'b0);
        push_token(TK_UNUSED, 16'hFFFF, 1'b1);
        // not (a or true) and b: close pops or, and pops not, flush pops and
        push_token(itpc_pkg::TK_NOT, 16'h0000, 1'b0);
        push_token(itpc_pkg::TK_OPEN, 16'hFFFF, 1'b0);
        push_token(itpc_pkg::TK_SURFACE, 16'hFFFF, 1'b0);
        push_token(itpc_pkg::TK_OR, 16'h0000, 1'b0);
        push_token(itpc_pkg::TK_TRUE, 16'hFFFF, 1'b0);
        push_token(itpc_pkg::TK_CLOSE, 16'h0000, 1'b0);
        push_token(itpc_pkg::TK_AND, 16'hFFFF, 1'b0);
        push_token(itpc_pkg::TK_SURFACE, 16'h5555, 1'b1);
        // chained not stays stacked until the flush
        push_token(itpc_pkg::TK_NOT, 16'h0000, 1'b0);
        push_token(itpc_pkg::TK_NOT, 16'h0000, 1'b0);
        push_token(itpc_pkg::TK_SURFACE, 16'hAAAA, 1'b1);
        // operand where an operator belongs, the rest dropped
        push_token(itpc_pkg::TK_SURFACE, 16'h0001, 1'b0);
        push_token(itpc_pkg::TK_SURFACE, 16'h0002, 1'b0);
        push_token(itpc_pkg::TK_TRUE, 16'h0003, 1'b1);
        // leading operator
        push_token(itpc_pkg::TK_OR, 16'h0000, 1'b1);
        // close with no open
        push_token(itpc_pkg::TK_SURFACE, 16'h1234, 1'b0);
        push_token(itpc_pkg::TK_CLOSE, 16'h0000, 1'b1);
        // open never closed
        push_token(itpc_pkg::TK_OPEN, 16'h0000, 1'b0);
        push_token(itpc_pkg::TK_SURFACE, 16'h4321, 1'b1);
        // ends on an operator
        push_token(itpc_pkg::TK_SURFACE, 16'h8000, 1'b0);
        push_token(itpc_pkg::TK_AND, 16'h0000, 1'b1);
        // final close releases nothing: silent end
        push_token(itpc_pkg::TK_OPEN, 16'h0000, 1'b0);
        push_token(itpc_pkg::TK_SURFACE, 16'h7FFF, 1'b0);
        push_token(itpc_pkg::TK_CLOSE, 16'h0000, 1'b1);
        send_tokens();
        hold_until_drained(8);

        // random expressions, mostly well-formed
        round = 0;
        while (sent_total < ITEM_GOAL)
        begin
            if (round % 15 == 0)
                gappy = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (round == 0)
                build_deep(itpc_pkg::TK_NOT, DEPTH);
            else if (round == 1)
                build_deep(itpc_pkg::TK_OPEN, DEPTH + 1);
            else if (pick < 2)
                build_deep(pick == 0 ? itpc_pkg::TK_NOT : itpc_pkg::TK_OPEN,
                           $urandom_range(DEPTH - 2, DEPTH + 2));
            else if (pick < 74)
            begin
                grow_expr(0);
                infix_q[$].last_token = 1'b1;
            end
            else if (pick < 90)
            begin
                grow_expr(0);
                scramble_tokens();
            end
            else
                make_noise();
            send_tokens();
            round++;
            if (round == 40)
                hold_until_drained(8);
        end

        hold_until_drained(DRAIN_CYCLES);
        if (mismatches == 0 && due_count == 0)
            $display("tb_infix_to_postfix_logic_converter: PASS");
        else
            $display("tb_infix_to_postfix_logic_converter: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("tb_infix_to_postfix_logic_converter: FAIL");
        $finish;
    end

endmodule
